FILE: rtl/tkcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the top-K class selection block.
package tkcs_pkg;

  localparam int TOPK_DEFAULT        = 16;
  localparam int MAX_CLASSES_DEFAULT = 4096;

  localparam int SCORE_W        = 16;
  localparam int CLASS_OUT_W    = 18;
  localparam int TOP_COUNT_W    = 7;
  localparam int CLASS_OFFSET_W = 12;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_TOP_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_OFFSET = 2'd1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] confidence;
    logic                      last_item;
  } item_word_t;

  typedef struct packed {
    logic signed [CLASS_OUT_W-1:0] class_index;
    logic signed [SCORE_W-1:0]     score;
    logic                          last_result;
  } result_word_t;

  // Broadcast to every cell of the chain; at most one is set per cycle.
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } chain_cmd_t;

endpackage

FILE: rtl/tkcs_cell.sv
`timescale 1ns / 1ps
// One compare-and-shift cell of the ranking chain.
module tkcs_cell #(
  parameter int CLS_W = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tkcs_pkg::chain_cmd_t                cmd,
  input  logic signed [tkcs_pkg::SCORE_W-1:0] new_score,
  input  logic [CLS_W-1:0]                    new_class,
  input  logic                                up_take,
  input  logic signed [tkcs_pkg::SCORE_W-1:0] up_score,
  input  logic [CLS_W-1:0]                    up_class,
  input  logic                                up_valid,
  input  logic signed [tkcs_pkg::SCORE_W-1:0] down_score,
  input  logic [CLS_W-1:0]                    down_class,
  input  logic                                down_valid,
  output logic                                take,
  output logic signed [tkcs_pkg::SCORE_W-1:0] score,
  output logic [CLS_W-1:0]                    class_id,
  output logic                                valid
);

  // Strictly greater: ties keep the earlier (lower) class ahead.
  assign take = !valid || (new_score > score);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert && take) begin
      valid <= up_take ? up_valid : 1'b1;
    end else if (cmd.shift) begin
      valid <= down_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && take) begin
      if (up_take) begin
        score    <= up_score;
        class_id <= up_class;
      end else begin
        score    <= new_score;
        class_id <= new_class;
      end
    end else if (cmd.shift) begin
      score    <= down_score;
      class_id <= down_class;
    end
  end

endmodule

FILE: rtl/top_k_class_select_top.sv
`timescale 1ns / 1ps
// Top level: streaming top-K class selection over a compare-and-shift chain.
//
// Scores arrive on the item channel, one per word, class numbers counted
// from 0 in arrival order. Each accepted score is ranked into a chain of TOPK
// cells in the cycle it is accepted, so outside a drain the block takes one
// score per cycle. Equal scores keep the lower class first. Scores past
// MAX_CLASSES are ignored. On the word marked last_item the chain drains
// from its head: the draining flag is set first and the first result is
// loaded into the output register after it, then one result per cycle while
// result_ready is high, min(kept, top_count) results in all, the final one
// marked last_result. A top_count of 0 or above TOPK means TOPK. While the
// chain drains item_ready is low; a stalled result sits in the output register
// and the drain simply waits. After the final result the chain is empty again.
// cfg_index 0 writes top_count, 1 writes class_offset; cfg_ready is always high.
// Reset empties the chain and class count and sets top_count 1, class_offset 0.
module top_k_class_select_top #(
  parameter int TOPK        = tkcs_pkg::TOPK_DEFAULT,
  parameter int MAX_CLASSES = tkcs_pkg::MAX_CLASSES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  tkcs_pkg::item_word_t                 item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output tkcs_pkg::result_word_t               result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tkcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tkcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CTR_W = $clog2(MAX_CLASSES + 1);
  localparam int CNT_W = $clog2(TOPK + 1);

  logic [tkcs_pkg::TOP_COUNT_W-1:0]           top_count;
  logic signed [tkcs_pkg::CLASS_OFFSET_W-1:0] class_offset;
  logic [CTR_W-1:0]                           class_counter;
  logic                                       draining;
  logic [CNT_W-1:0]                           emit_cnt;
  logic [CNT_W-1:0]                           want;

  tkcs_pkg::chain_cmd_t chain_cmd;

  // Index i+1 is cell i; 0 and TOPK+1 are the empty ends of the chain.
  logic signed [tkcs_pkg::SCORE_W-1:0] c_score [TOPK+2];
  logic [CLS_W-1:0]                    c_class [TOPK+2];
  logic                                c_valid [TOPK+2];
  logic                                c_take  [TOPK];
  logic [TOPK-1:0]                     valid_vec;

  logic item_acc, do_insert, load, final_one;

  assign cfg_ready  = 1'b1;
  assign item_ready = !draining;
  assign item_acc   = item_valid && item_ready;
  assign do_insert  = item_acc && (class_counter < CTR_W'(MAX_CLASSES));

  always_comb begin
    if (top_count == '0 || top_count > tkcs_pkg::TOP_COUNT_W'(TOPK)) begin
      want = CNT_W'(TOPK);
    end else begin
      want = top_count[CNT_W-1:0];
    end
  end

  assign load      = draining && (!result_valid || result_ready);
  assign final_one = ((CNT_W+1)'(emit_cnt) + 1'b1 == (CNT_W+1)'(want)) || !c_valid[2];

  always_comb begin
    chain_cmd.insert = do_insert;
    chain_cmd.shift  = load && !final_one;
    chain_cmd.clear  = load && final_one;
  end

  assign c_score[0]      = '0;
  assign c_class[0]      = '0;
  assign c_valid[0]      = 1'b0;
  assign c_score[TOPK+1] = '0;
  assign c_class[TOPK+1] = '0;
  assign c_valid[TOPK+1] = 1'b0;

  for (genvar i = 0; i < TOPK; i++) begin : g_cell
    localparam int UP = (i == 0) ? 0 : i - 1;
    tkcs_cell #(.CLS_W(CLS_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (chain_cmd),
      .new_score  (item.confidence),
      .new_class  (class_counter[CLS_W-1:0]),
      .up_take    ((i == 0) ? 1'b0 : c_take[UP]),
      .up_score   (c_score[i]),
      .up_class   (c_class[i]),
      .up_valid   (c_valid[i]),
      .down_score (c_score[i+2]),
      .down_class (c_class[i+2]),
      .down_valid (c_valid[i+2]),
      .take       (c_take[i]),
      .score      (c_score[i+1]),
      .class_id   (c_class[i+1]),
      .valid      (c_valid[i+1])
    );
    assign valid_vec[i] = c_valid[i+1];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count    <= tkcs_pkg::TOP_COUNT_W'(1);
      class_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tkcs_pkg::REG_TOP_COUNT:
          top_count <= cfg_data[tkcs_pkg::TOP_COUNT_W-1:0];
        tkcs_pkg::REG_CLASS_OFFSET:
          class_offset <= cfg_data[tkcs_pkg::CLASS_OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_counter <= '0;
      draining      <= 1'b0;
      emit_cnt      <= '0;
    end else begin
      if (item_acc) begin
        if (item.last_item) begin
          class_counter <= '0;
          draining      <= 1'b1;
        end else if (do_insert) begin
          class_counter <= class_counter + 1'b1;
        end
      end
      if (load) begin
        if (final_one) begin
          draining <= 1'b0;
          emit_cnt <= '0;
        end else begin
          emit_cnt <= emit_cnt + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.class_index <= tkcs_pkg::CLASS_OUT_W'(c_class[1])
                          + tkcs_pkg::CLASS_OUT_W'(class_offset);
      result.score       <= c_score[1];
      result.last_result <= final_one;
    end
  end

  // Kept entries always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("chain valid bits not a prefix");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    draining |-> c_valid[1])
    else $error("drain with empty chain head");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    draining |-> (emit_cnt < want))
    else $error("emit count past requested results");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({chain_cmd.insert, chain_cmd.shift, chain_cmd.clear}) <= 1)
    else $error("conflicting chain commands");

  a_end_run: assert property (@(posedge clk) disable iff (rst)
    (load && final_one) |=> (!draining && valid_vec == '0 && class_counter == '0))
    else $error("chain not cleared after final result");

endmodule
